// ----- rtl/rcf_pkg.sv -----
// ----------------------------------------------------------------------------
// rcf_pkg
// shared constants and types for the rectangle and circle fill engine
// ----------------------------------------------------------------------------
package rcf_pkg;

    localparam int FRAME_WIDTH  = 300;
    localparam int FRAME_HEIGHT = 200;
    localparam int PIXEL_COUNT  = FRAME_WIDTH * FRAME_HEIGHT;

    localparam int ADDR_W  = $clog2(PIXEL_COUNT);
    localparam int COL_W   = $clog2(FRAME_WIDTH);
    localparam int ROW_W   = $clog2(FRAME_HEIGHT);
    localparam int COLOR_W = 24;

    // square root unit over a 20 bit radicand
    localparam int              SQRT_W       = 20;
    localparam logic [SQRT_W-1:0] SQRT_BIT_TOP = SQRT_W'(1) << (SQRT_W - 2);
    localparam logic [SQRT_W-1:0] SQRT_BIT_LAST = SQRT_W'(1);

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_RECT   = 2'd1,
        MODE_CIRCLE = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ROW,
        ST_SQRT_LOAD,
        ST_SQRT,
        ST_SPAN,
        ST_PIX,
        ST_READ,
        ST_READ_DATA,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/rcf_ram.sv -----
// ----------------------------------------------------------------------------
// rcf_ram
// generic simple dual port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module rcf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/rect_circle_fill_engine.sv -----
// ----------------------------------------------------------------------------
// rect_circle_fill_engine
// frame store rasteriser: clear, rectangle fill, disc fill and pixel read
// ----------------------------------------------------------------------------
// usage
//   cmd channel (cmd_valid/cmd_ready) takes one command word: mode, x_pos,
//   y_pos, extent_a, extent_b. cmd_ready is high only while the sequencer is
//   idle; one command is worked on at a time.
//   rsp channel (rsp_valid/rsp_ready) returns one word per command: the
//   pixel colour and in_frame for a read, zeros for drawing commands.
//   fill_color is written through cfg_write_en/cfg_write_data, no wait.
//   one frame store write port sets the pace of the drawing commands:
//     clear        writes every pixel of the frame in address order
//     rectangle    skips hidden rows and writes the visible span of each
//                  visible row; nothing when width or height is zero
//     disc         as rectangle, with a square root per visible row first
//     read         one frame store read, none when outside the frame
//   the result sits in an output register; a stalled receiver only holds
//   the next command at its end, waiting for that register to empty.
//   reset clears the sequencer, the response valid flag and fill_color; the
//   frame store holds no reset value and must be drawn before it is read.
// ----------------------------------------------------------------------------
module rect_circle_fill_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  logic [1:0]                        mode,
    input  logic signed [10:0]                x_pos,
    input  logic signed [10:0]                y_pos,
    input  logic [9:0]                        extent_a,
    input  logic [9:0]                        extent_b,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic [rcf_pkg::COLOR_W-1:0]       read_color,
    output logic                              in_frame,
    input  logic                              cfg_write_en,
    input  logic [rcf_pkg::COLOR_W-1:0]       cfg_write_data
);

    localparam int AW = rcf_pkg::ADDR_W;
    localparam int CW = rcf_pkg::COL_W;
    localparam int RW = rcf_pkg::ROW_W;
    localparam int SW = rcf_pkg::SQRT_W;
    localparam int KW = rcf_pkg::COLOR_W;

    // control registers
    rcf_pkg::state_t state_reg, state_next;
    logic            rsp_valid_reg, rsp_valid_next;
    logic [KW-1:0]   fill_color_reg, fill_color_next;

    // working registers
    logic signed [10:0] x_reg, x_next;
    logic signed [10:0] y_reg, y_next;
    logic [9:0]         a_reg, a_next;
    logic               circle_reg, circle_next;
    logic signed [11:0] d_reg, d_next;
    logic signed [11:0] d_end_reg, d_end_next;
    logic [SW-1:0]      rr_reg, rr_next;
    logic [SW-1:0]      dd2_reg, dd2_next;
    logic [SW-1:0]      n_reg, n_next;
    logic [SW-1:0]      root_reg, root_next;
    logic [SW-1:0]      bit_reg, bit_next;
    logic [9:0]         span_half_width_reg, span_half_width_next;
    logic [RW-1:0]      row_counter_reg, row_counter_next;
    logic [AW-1:0]      row_base_reg, row_base_next;
    logic [CW-1:0]      column_counter_reg, column_counter_next;
    logic [CW-1:0]      col_end_reg, col_end_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [KW-1:0]      res_color_reg, res_color_next;
    logic               res_in_frame_reg, res_in_frame_next;
    logic [KW-1:0]      read_color_reg, read_color_next;
    logic               in_frame_reg, in_frame_next;

    // frame store
    logic          ram_we;
    logic          ram_re;
    logic [KW-1:0] ram_rdata;

    // datapath terms
    logic signed [12:0] x_ext;
    logic signed [12:0] y_ext;
    logic signed [12:0] row_calc;
    logic [9:0]         d_abs;
    logic signed [12:0] span_c0;
    logic signed [12:0] span_c1;
    logic signed [12:0] span_lo;
    logic signed [12:0] span_hi;
    logic [SW:0]        sqrt_trial;
    logic [SW-1:0]      sqrt_root_step;
    logic               read_inside;

    rcf_ram #(
        .WIDTH (KW),
        .DEPTH (rcf_pkg::PIXEL_COUNT)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (fill_color_reg),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rcf_pkg::ST_IDLE;
            rsp_valid_reg  <= 1'b0;
            fill_color_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rsp_valid_reg  <= rsp_valid_next;
            fill_color_reg <= fill_color_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg               <= x_next;
        y_reg               <= y_next;
        a_reg               <= a_next;
        circle_reg          <= circle_next;
        d_reg               <= d_next;
        d_end_reg           <= d_end_next;
        rr_reg              <= rr_next;
        dd2_reg             <= dd2_next;
        n_reg               <= n_next;
        root_reg            <= root_next;
        bit_reg             <= bit_next;
        span_half_width_reg <= span_half_width_next;
        row_counter_reg     <= row_counter_next;
        row_base_reg        <= row_base_next;
        column_counter_reg  <= column_counter_next;
        col_end_reg         <= col_end_next;
        addr_reg            <= addr_next;
        res_color_reg       <= res_color_next;
        res_in_frame_reg    <= res_in_frame_next;
        read_color_reg      <= read_color_next;
        in_frame_reg        <= in_frame_next;
    end

    // shared datapath terms
    always_comb
    begin
        x_ext    = 13'(x_reg);
        y_ext    = 13'(y_reg);
        row_calc = y_ext + 13'(d_reg);
        d_abs    = d_reg[11] ? 10'(-d_reg) : d_reg[9:0];

        if (circle_reg)
        begin
            span_c0 = x_ext - $signed({3'b000, span_half_width_reg});
            span_c1 = x_ext + $signed({3'b000, span_half_width_reg});
        end
        else
        begin
            span_c0 = x_ext;
            span_c1 = x_ext + $signed({3'b000, a_reg}) - 13'sd1;
        end
        span_lo = (span_c0 < 13'sd0) ? 13'sd0 : span_c0;
        span_hi = (span_c1 > $signed(13'(rcf_pkg::FRAME_WIDTH - 1)))
                  ? $signed(13'(rcf_pkg::FRAME_WIDTH - 1)) : span_c1;

        sqrt_trial     = {1'b0, root_reg} + {1'b0, bit_reg};
        sqrt_root_step = root_reg >> 1;

        read_inside = (x_pos >= 11'sd0)
                   && ($signed(13'(x_pos)) < $signed(13'(rcf_pkg::FRAME_WIDTH)))
                   && (y_pos >= 11'sd0)
                   && ($signed(13'(y_pos)) < $signed(13'(rcf_pkg::FRAME_HEIGHT)));
    end

    // sequencer
    always_comb
    begin
        state_next           = state_reg;
        rsp_valid_next       = rsp_valid_reg;
        fill_color_next      = fill_color_reg;
        x_next               = x_reg;
        y_next               = y_reg;
        a_next               = a_reg;
        circle_next          = circle_reg;
        d_next               = d_reg;
        d_end_next           = d_end_reg;
        rr_next              = rr_reg;
        dd2_next             = dd2_reg;
        n_next               = n_reg;
        root_next            = root_reg;
        bit_next             = bit_reg;
        span_half_width_next = span_half_width_reg;
        row_counter_next     = row_counter_reg;
        row_base_next        = row_base_reg;
        column_counter_next  = column_counter_reg;
        col_end_next         = col_end_reg;
        addr_next            = addr_reg;
        res_color_next       = res_color_reg;
        res_in_frame_next    = res_in_frame_reg;
        read_color_next      = read_color_reg;
        in_frame_next        = in_frame_reg;
        ram_we               = 1'b0;
        ram_re               = 1'b0;
        cmd_ready            = 1'b0;

        if (cfg_write_en)
        begin
            fill_color_next = cfg_write_data;
        end

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            rcf_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    x_next            = x_pos;
                    y_next            = y_pos;
                    a_next            = extent_a;
                    res_color_next    = '0;
                    res_in_frame_next = 1'b0;
                    case (rcf_pkg::mode_t'(mode))
                        rcf_pkg::MODE_CLEAR:
                        begin
                            addr_next  = '0;
                            state_next = rcf_pkg::ST_CLEAR;
                        end
                        rcf_pkg::MODE_RECT:
                        begin
                            circle_next = 1'b0;
                            d_next      = '0;
                            d_end_next  = $signed({2'b00, extent_b}) - 12'sd1;
                            if (extent_a == '0 || extent_b == '0)
                            begin
                                state_next = rcf_pkg::ST_DONE;
                            end
                            else
                            begin
                                state_next = rcf_pkg::ST_ROW;
                            end
                        end
                        rcf_pkg::MODE_CIRCLE:
                        begin
                            circle_next = 1'b1;
                            d_next      = -$signed({2'b00, extent_a});
                            d_end_next  = $signed({2'b00, extent_a});
                            rr_next     = SW'(extent_a) * SW'(extent_a);
                            state_next  = rcf_pkg::ST_ROW;
                        end
                        default:
                        begin
                            if (read_inside)
                            begin
                                addr_next = AW'(AW'(y_pos[RW-1:0])
                                            * AW'(rcf_pkg::FRAME_WIDTH))
                                            + AW'(x_pos[CW-1:0]);
                                state_next = rcf_pkg::ST_READ;
                            end
                            else
                            begin
                                state_next = rcf_pkg::ST_DONE;
                            end
                        end
                    endcase
                end
            end

            rcf_pkg::ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (addr_reg == AW'(rcf_pkg::PIXEL_COUNT - 1))
                begin
                    state_next = rcf_pkg::ST_DONE;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end

            rcf_pkg::ST_ROW:
            begin
                if (d_reg > d_end_reg)
                begin
                    state_next = rcf_pkg::ST_DONE;
                end
                else if (row_calc < 13'sd0
                         || row_calc >= $signed(13'(rcf_pkg::FRAME_HEIGHT)))
                begin
                    d_next = d_reg + 12'sd1;
                end
                else
                begin
                    row_counter_next = row_calc[RW-1:0];
                    row_base_next    = AW'(AW'(row_calc[RW-1:0])
                                       * AW'(rcf_pkg::FRAME_WIDTH));
                    dd2_next         = SW'(d_abs) * SW'(d_abs);
                    state_next       = circle_reg ? rcf_pkg::ST_SQRT_LOAD
                                                  : rcf_pkg::ST_SPAN;
                end
            end

            rcf_pkg::ST_SQRT_LOAD:
            begin
                n_next     = rr_reg - dd2_reg;
                root_next  = '0;
                bit_next   = rcf_pkg::SQRT_BIT_TOP;
                state_next = rcf_pkg::ST_SQRT;
            end

            rcf_pkg::ST_SQRT:
            begin
                if ({1'b0, n_reg} >= sqrt_trial)
                begin
                    n_next    = n_reg - sqrt_trial[SW-1:0];
                    root_next = sqrt_root_step + bit_reg;
                end
                else
                begin
                    root_next = sqrt_root_step;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg == rcf_pkg::SQRT_BIT_LAST)
                begin
                    span_half_width_next = root_next[9:0];
                    state_next           = rcf_pkg::ST_SPAN;
                end
            end

            rcf_pkg::ST_SPAN:
            begin
                if (span_lo > span_hi)
                begin
                    d_next     = d_reg + 12'sd1;
                    state_next = rcf_pkg::ST_ROW;
                end
                else
                begin
                    column_counter_next = span_lo[CW-1:0];
                    col_end_next        = span_hi[CW-1:0];
                    addr_next           = row_base_reg + AW'(span_lo[CW-1:0]);
                    state_next          = rcf_pkg::ST_PIX;
                end
            end

            rcf_pkg::ST_PIX:
            begin
                ram_we = 1'b1;
                if (column_counter_reg == col_end_reg)
                begin
                    d_next     = d_reg + 12'sd1;
                    state_next = rcf_pkg::ST_ROW;
                end
                else
                begin
                    column_counter_next = column_counter_reg + CW'(1);
                    addr_next           = addr_reg + AW'(1);
                end
            end

            rcf_pkg::ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = rcf_pkg::ST_READ_DATA;
            end

            rcf_pkg::ST_READ_DATA:
            begin
                res_color_next    = ram_rdata;
                res_in_frame_next = 1'b1;
                state_next        = rcf_pkg::ST_DONE;
            end

            rcf_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    read_color_next = res_color_reg;
                    in_frame_next   = res_in_frame_reg;
                    rsp_valid_next  = 1'b1;
                    state_next      = rcf_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rcf_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp_valid  = rsp_valid_reg;
    assign read_color = read_color_reg;
    assign in_frame   = in_frame_reg;

endmodule

// ----- tb/sv/tb_rect_circle_fill_engine.sv -----
// ----------------------------------------------------------------------------
// tb_rect_circle_fill_engine
// self-checking bench for the rectangle and disc fill engine
// scoreboard keeps its own frame copy and fill colour, repaints every
// accepted command and queues the expected word
// opens with a clear so no pixel is read before it is drawn, then directed
// clipping, empty shape and outside reads, then random segments each under
// a new fill colour, random stalls on both sides and one long hold-off
// ----------------------------------------------------------------------------

typedef struct {
    rcf_pkg::mode_t     mode;
    logic signed [10:0] x;
    logic signed [10:0] y;
    logic [9:0]         ext_a;
    logic [9:0]         ext_b;
} draw_cmd_t;

typedef struct {
    logic [rcf_pkg::COLOR_W-1:0] color;
    logic                        in_bounds;
} readback_t;

class pixel_scoreboard;
    bit [rcf_pkg::COLOR_W-1:0] frame [rcf_pkg::PIXEL_COUNT];
    bit [rcf_pkg::COLOR_W-1:0] fill;
    readback_t                 expected_readback [$];
    int                        fails;
    int                        mode_count [4];
    int                        inside_reads;

    function int floor_root(int n);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = 1024;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) / 2;
            if (mid * mid <= n)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function void paint_span(int row, int c0, int c1);
        if (row < 0 || row >= rcf_pkg::FRAME_HEIGHT)
            return;
        if (c0 < 0)
            c0 = 0;
        if (c1 > rcf_pkg::FRAME_WIDTH - 1)
            c1 = rcf_pkg::FRAME_WIDTH - 1;
        for (int c = c0; c <= c1; c++)
            frame[row * rcf_pkg::FRAME_WIDTH + c] = fill;
    endfunction

    function void note_command(draw_cmd_t c);
        int        xi;
        int        yi;
        int        a;
        int        b;
        int        h;
        readback_t r;
        xi = c.x;
        yi = c.y;
        a = c.ext_a;
        b = c.ext_b;
        r.color = '0;
        r.in_bounds = 1'b0;
        mode_count[c.mode]++;
        case (c.mode)
            rcf_pkg::MODE_CLEAR:
                foreach (frame[i])
                    frame[i] = fill;
            rcf_pkg::MODE_RECT:
                if (a > 0)
                begin
                    for (int row = yi; row < yi + b; row++)
                        paint_span(row, xi, xi + a - 1);
                end
            rcf_pkg::MODE_CIRCLE:
                for (int d = -a; d <= a; d++)
                begin
                    h = floor_root(a * a - d * d);
                    paint_span(yi + d, xi - h, xi + h);
                end
            rcf_pkg::MODE_READ:
                if (xi >= 0 && xi < rcf_pkg::FRAME_WIDTH &&
                    yi >= 0 && yi < rcf_pkg::FRAME_HEIGHT)
                begin
                    r.color = frame[yi * rcf_pkg::FRAME_WIDTH + xi];
                    r.in_bounds = 1'b1;
                    inside_reads++;
                end
            default:
                ;
        endcase
        expected_readback.push_back(r);
    endfunction

    function void check_readback(logic [rcf_pkg::COLOR_W-1:0] color, logic in_bounds);
        readback_t e;
        if (expected_readback.size() == 0)
        begin
            $error("result word with no command waiting: read_color %06h in_frame %0b",
                   color, in_bounds);
            fails++;
            return;
        end
        e = expected_readback.pop_front();
        if (color !== e.color)
        begin
            $error("read_color mismatch: expected %06h, actual %06h", e.color, color);
            fails++;
        end
        if (in_bounds !== e.in_bounds)
        begin
            $error("in_frame mismatch: expected %0b, actual %0b", e.in_bounds, in_bounds);
            fails++;
        end
    endfunction

    function int pending();
        return expected_readback.size();
    endfunction
endclass

module tb_rect_circle_fill_engine;

    localparam int          LONG_HOLD   = 400;
    localparam int unsigned CYCLE_LIMIT = 32_000_000;

    logic                          clk;
    logic                          rst_n;
    logic                          cmd_valid;
    logic                          cmd_ready;
    logic [1:0]                    mode;
    logic signed [10:0]            x_pos;
    logic signed [10:0]            y_pos;
    logic [9:0]                    extent_a;
    logic [9:0]                    extent_b;
    logic                          rsp_valid;
    logic                          rsp_ready;
    logic [rcf_pkg::COLOR_W-1:0]   read_color;
    logic                          in_frame;
    logic                          cfg_write_en;
    logic [rcf_pkg::COLOR_W-1:0]   cfg_write_data;

    pixel_scoreboard      sb;
    bit                   no_idle;
    bit                   hold_req;
    int                   colours_used;
    int                   last_x;
    int                   last_y;
    int                   last_r;
    int unsigned          cycle_count;

    rect_circle_fill_engine dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .mode           (mode),
        .x_pos          (x_pos),
        .y_pos          (y_pos),
        .extent_a       (extent_a),
        .extent_b       (extent_b),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .read_color     (read_color),
        .in_frame       (in_frame),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[rect_circle_fill_engine] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_readback(read_color, in_frame);

    // receiver: short random stalls, calm stretches, one long hold-off on request
    initial
    begin
        rsp_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
                rsp_ready <= 1'b1;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                rsp_ready <= 1'b1;
            end
            else if ($urandom_range(0, 63) == 0)
            begin
                rsp_ready <= 1'b1;
                repeat ($urandom_range(20, 200)) @(posedge clk);
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    function automatic draw_cmd_t make_cmd(rcf_pkg::mode_t m, int x, int y, int a, int b);
        draw_cmd_t c;
        c.mode = m;
        c.x = 11'(x);
        c.y = 11'(y);
        c.ext_a = 10'(a);
        c.ext_b = 10'(b);
        return c;
    endfunction

    function automatic int clamp(int v, int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    function automatic draw_cmd_t random_cmd();
        int pick;
        int x;
        int y;
        int a;
        int b;
        int span;
        pick = $urandom_range(0, 99);
        x = $urandom_range(0, 339) - 20;
        y = $urandom_range(0, 239) - 20;
        a = $urandom_range(0, 40);
        b = $urandom_range(0, 40);
        if (pick < 3)
            return make_cmd(rcf_pkg::MODE_CLEAR, $urandom, $urandom, $urandom, $urandom);
        if (pick < 55)
        begin
            if (pick >= 33)
                a = $urandom_range(0, 24);
            // now and then a shape of any size anywhere
            if ($urandom_range(0, 19) == 0)
            begin
                x = $urandom_range(0, 2047) - 1024;
                y = $urandom_range(0, 2047) - 1024;
                a = $urandom_range(0, 1023);
                b = $urandom_range(0, 1023);
            end
            last_x = x;
            last_y = y;
            last_r = a;
            if (pick < 33)
                return make_cmd(rcf_pkg::MODE_RECT, x, y, a, b);
            return make_cmd(rcf_pkg::MODE_CIRCLE, x, y, a, $urandom);
        end
        if ($urandom_range(0, 6) == 0)
            return make_cmd(rcf_pkg::MODE_READ, $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(0, 1) == 0)
        begin
            // read back around the last shape drawn
            span = ((last_r > 40) ? 40 : last_r) + 2;
            x = clamp(last_x + $urandom_range(0, 2 * span) - span,
                      rcf_pkg::FRAME_WIDTH - 1);
            y = clamp(last_y + $urandom_range(0, 2 * span) - span,
                      rcf_pkg::FRAME_HEIGHT - 1);
        end
        else
        begin
            x = $urandom_range(0, rcf_pkg::FRAME_WIDTH - 1);
            y = $urandom_range(0, rcf_pkg::FRAME_HEIGHT - 1);
        end
        return make_cmd(rcf_pkg::MODE_READ, x, y, $urandom, $urandom);
    endfunction

    // called at a rising edge; leaves cmd_valid high after the word is taken
    task automatic send_cmd(input draw_cmd_t c);
        cmd_valid <= 1'b1;
        mode      <= c.mode;
        x_pos     <= c.x;
        y_pos     <= c.y;
        extent_a  <= c.ext_a;
        extent_b  <= c.ext_b;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        sb.note_command(c);
    endtask

    task automatic sender_gap();
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        cmd_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_fill(input logic [rcf_pkg::COLOR_W-1:0] colour);
        cfg_write_data <= colour;
        cfg_write_en   <= 1'b1;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        sb.fill = colour;
        colours_used++;
    endtask

    // receiver held off while reads keep coming, so the block backs up
    task automatic pressure_burst();
        hold_req = 1'b1;
        repeat (8)
            send_cmd(make_cmd(rcf_pkg::MODE_READ,
                              $urandom_range(0, rcf_pkg::FRAME_WIDTH - 1),
                              $urandom_range(0, rcf_pkg::FRAME_HEIGHT - 1),
                              $urandom, $urandom));
    endtask

    task automatic run_directed();
        // clear under the reset colour first, so every pixel is written
        send_cmd(make_cmd(rcf_pkg::MODE_CLEAR, 0, 0, 0, 0));
        send_cmd(make_cmd(rcf_pkg::MODE_READ, 0, 0, 0, 0));
        send_cmd(make_cmd(rcf_pkg::MODE_READ, 299, 199, 1023, 1023));
        wait_idle();
        write_fill(24'hFFFFFF);
        send_cmd(make_cmd(rcf_pkg::MODE_RECT, 10, 10, 0, 5));
        send_cmd(make_cmd(rcf_pkg::MODE_RECT, 20, 20, 5, 0));
        send_cmd(make_cmd(rcf_pkg::MODE_RECT, -3, -3, 6, 6));
        send_cmd(make_cmd(rcf_pkg::MODE_RECT, 297, 197, 10, 10));
        send_cmd(make_cmd(rcf_pkg::MODE_CIRCLE, 150, 100, 0, 0));
        send_cmd(make_cmd(rcf_pkg::MODE_CIRCLE, 0, 0, 5, 1023));
        send_cmd(make_cmd(rcf_pkg::MODE_CIRCLE, -1024, -1024, 1023, 0));
        send_cmd(make_cmd(rcf_pkg::MODE_READ, 2, 2, 0, 0));
        send_cmd(make_cmd(rcf_pkg::MODE_READ, 10, 10, 0, 0));
        send_cmd(make_cmd(rcf_pkg::MODE_READ, 299, 199, 0, 0));
        send_cmd(make_cmd(rcf_pkg::MODE_READ, 150, 100, 0, 0));
        send_cmd(make_cmd(rcf_pkg::MODE_READ, 151, 100, 0, 0));
        send_cmd(make_cmd(rcf_pkg::MODE_READ, 4, 4, 0, 0));
        send_cmd(make_cmd(rcf_pkg::MODE_READ, -1, 0, 1023, 1023));
        send_cmd(make_cmd(rcf_pkg::MODE_READ, 300, 0, 0, 0));
        send_cmd(make_cmd(rcf_pkg::MODE_READ, 0, 200, 0, 0));
        send_cmd(make_cmd(rcf_pkg::MODE_READ, 1023, -1024, 0, 0));
        wait_idle();
        write_fill(24'h5A3C96);
        send_cmd(make_cmd(rcf_pkg::MODE_RECT, 0, 50, 1023, 3));
        send_cmd(make_cmd(rcf_pkg::MODE_RECT, 298, -5, 2, 1023));
        send_cmd(make_cmd(rcf_pkg::MODE_CIRCLE, 1023, 1023, 1023, 1023));
        send_cmd(make_cmd(rcf_pkg::MODE_READ, 299, 52, 0, 0));
        send_cmd(make_cmd(rcf_pkg::MODE_READ, 299, 199, 0, 0));
    endtask

    initial
    begin
        logic [rcf_pkg::COLOR_W-1:0] colour;
        sb             = new;
        rst_n          = 1'b0;
        cmd_valid      = 1'b0;
        mode           = rcf_pkg::MODE_CLEAR;
        x_pos          = '0;
        y_pos          = '0;
        extent_a       = '0;
        extent_b       = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        for (int seg = 0; seg < 4; seg++)
        begin
            wait_idle();
            case (seg)
                0:       colour = 24'h000000;
                2:       colour = 24'hFFFFFF;
                default: colour = (rcf_pkg::COLOR_W)'($urandom);
            endcase
            write_fill(colour);
            if (seg == 3)
                no_idle = 1'b1;
            for (int n = 0; n < 18; n++)
            begin
                if (seg == 1 && n == 10)
                    pressure_burst();
                if (seg == 2 && n == 12)
                    wait_idle();
                sender_gap();
                send_cmd(random_cmd());
            end
        end
        wait_idle();
        repeat (20) @(posedge clk);
        $display("covered %0d clears, %0d rectangles, %0d discs, %0d reads (%0d inside)",
                 sb.mode_count[rcf_pkg::MODE_CLEAR], sb.mode_count[rcf_pkg::MODE_RECT],
                 sb.mode_count[rcf_pkg::MODE_CIRCLE], sb.mode_count[rcf_pkg::MODE_READ],
                 sb.inside_reads);
        $display("fill colours written: %0d, receiver hold-off of %0d cycles, %0d cycles",
                 colours_used, LONG_HOLD, cycle_count);
        if (sb.fails == 0)
            $display("[rect_circle_fill_engine] OK");
        else
            $display("[rect_circle_fill_engine] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/rcf_pkg.sv
rtl/rcf_ram.sv
rtl/rect_circle_fill_engine.sv
tb/sv/tb_rect_circle_fill_engine.sv
